FILE: hdl/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

   localparam int unsigned EPOCH_W  = 32;
   localparam int unsigned ZONE_W   = 5;
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned MDAY_W   = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;

   localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd8;
   localparam int unsigned SEC_PER_HOUR = 3600;

   // seconds per day is 675 << 7
   localparam int unsigned LOCAL_W     = EPOCH_W + 1;
   localparam int unsigned DAY_LO_W    = 7;
   localparam int unsigned DAY_X_W     = LOCAL_W - DAY_LO_W;
   localparam int unsigned DAY_DIV     = 675;
   localparam int unsigned DAY_RECIP_W = 17;
   localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 17'd99420;
   localparam int unsigned DAY_SHIFT   = 26;
   localparam int unsigned DAY_PROD_W  = DAY_X_W + DAY_RECIP_W;
   localparam int unsigned DAY_REM_W   = 11;
   localparam int unsigned DAY_R_W     = 10;
   localparam int unsigned DAYS_W      = 16;
   localparam int unsigned SOD_W       = DAY_R_W + DAY_LO_W;

   // years counted from 1969 in units of 1461 days, 2100 patched by one day
   localparam int unsigned BASE_YEAR       = 1970;
   localparam int unsigned YEAR_2101_START = 47847;
   localparam int unsigned YR_V_W          = 18;
   localparam int unsigned YR_BIAS         = 1463;
   localparam int unsigned YR_CYCLE        = 1461;
   localparam int unsigned YR_RECIP_W      = 8;
   localparam logic [YR_RECIP_W-1:0] YR_RECIP = 8'd179;
   localparam int unsigned YR_PROD_W       = YR_V_W + YR_RECIP_W;
   localparam int unsigned YR_MUL_W        = 19;
   localparam int unsigned YR_REM_W        = 12;
   localparam int unsigned YR_IDX_W        = 8;
   localparam int unsigned YR_2100_IDX     = 130;
   localparam int unsigned DOY_W           = 9;

   // division by 60 as (x >> 2) / 15
   localparam int unsigned MIN_RECIP_W = 12;
   localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = 12'd2184;
   localparam int unsigned MIN_SHIFT   = 15;
   localparam int unsigned MIN_PROD_W  = 27;
   localparam int unsigned MT_W        = 11;
   localparam int unsigned MT_REM_W    = 7;
   localparam int unsigned HR_PROD_W   = 21;
   localparam int unsigned SIXTY       = 60;

   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [SOD_W-1:0]  sod;
   } day_split_type;

   function automatic logic [DAYS_W-1:0] year_start(input logic [YR_IDX_W-1:0] n);
      logic [DAYS_W-1:0] base;
      logic [DAYS_W-1:0] leaps;
      base  = DAYS_W'(n) * DAYS_W'(365);
      // leap years 1972, 1976, ... before year 1970 + n
      leaps = DAYS_W'(((YR_IDX_W + 1)'(n) + (YR_IDX_W + 1)'(1)) >> 2);
      if (n > YR_IDX_W'(YR_2100_IDX)) begin
         leaps = leaps - DAYS_W'(1);
      end
      return base + leaps;
   endfunction

   function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      logic [DOY_W-1:0] s;
      case (m)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd59;
         4'd3:    s = 9'd90;
         4'd4:    s = 9'd120;
         4'd5:    s = 9'd151;
         4'd6:    s = 9'd181;
         4'd7:    s = 9'd212;
         4'd8:    s = 9'd243;
         4'd9:    s = 9'd273;
         4'd10:   s = 9'd304;
         4'd11:   s = 9'd334;
         default: s = 9'd0;
      endcase
      if (leap && m >= 4'd2) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

endpackage

FILE: hdl/stc_req_if.sv
`timescale 1ns / 1ps

interface stc_req_if;
   logic                         valid;
   logic                         ready;
   logic [stc_pkg::EPOCH_W-1:0]  epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

FILE: hdl/stc_rsp_if.sv
`timescale 1ns / 1ps

interface stc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [stc_pkg::YEAR_W-1:0]    year;
   logic [stc_pkg::MONTH_W-1:0]   month;
   logic [stc_pkg::MDAY_W-1:0]    day_of_month;
   logic [stc_pkg::HOUR_W-1:0]    hour;
   logic [stc_pkg::MINUTE_W-1:0]  minute;
   logic [stc_pkg::SECOND_W-1:0]  second;

   modport source (output valid, output year, output month, output day_of_month,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day_of_month,
                   input hour, input minute, input second, output ready);
endinterface

FILE: hdl/stc_day_split.sv
`timescale 1ns / 1ps

module stc_day_split (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [stc_pkg::EPOCH_W-1:0] epoch_seconds,
   input  logic [stc_pkg::ZONE_W-1:0]  zone_offset_hours,
   output logic                        out_valid,
   output stc_pkg::day_split_type      out_split
);
   import stc_pkg::*;

   localparam int unsigned STAGES = 4;

   logic [STAGES-1:0]    valid_ff, valid_in;

   logic [LOCAL_W-1:0]   local_sec_ff, local_sec_in;

   logic [DAY_PROD_W-1:0] day_prod;
   logic [DAYS_W-1:0]    q1_ff, q1_in;
   logic [DAY_X_W-1:0]   x1_ff, x1_in;
   logic [DAY_LO_W-1:0]  lo1_ff, lo1_in;

   logic [DAY_X_W-1:0]   q_mul;
   logic [DAYS_W-1:0]    q2_ff, q2_in;
   logic [DAY_REM_W-1:0] r2_ff, r2_in;
   logic [DAY_LO_W-1:0]  lo2_ff, lo2_in;

   day_split_type        split_ff, split_in;
   logic [DAY_REM_W-1:0] r_fix;

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   // stage 0: local seconds
   assign local_sec_in = LOCAL_W'(epoch_seconds)
                       + LOCAL_W'(zone_offset_hours) * LOCAL_W'(SEC_PER_HOUR);

   // stage 1: day estimate, may be one low
   assign day_prod = DAY_PROD_W'(local_sec_ff[LOCAL_W-1:DAY_LO_W]) * DAY_PROD_W'(DAY_RECIP);
   assign q1_in    = day_prod[DAY_SHIFT +: DAYS_W];
   assign x1_in    = local_sec_ff[LOCAL_W-1:DAY_LO_W];
   assign lo1_in   = local_sec_ff[DAY_LO_W-1:0];

   // stage 2: remainder of the estimate
   assign q_mul  = DAY_X_W'(q1_ff) * DAY_X_W'(DAY_DIV);
   assign r2_in  = DAY_REM_W'(x1_ff - q_mul);
   assign q2_in  = q1_ff;
   assign lo2_in = lo1_ff;

   // stage 3: correction
   always_comb begin
      if (r2_ff >= DAY_REM_W'(DAY_DIV)) begin
         split_in.days = q2_ff + DAYS_W'(1);
         r_fix         = r2_ff - DAY_REM_W'(DAY_DIV);
      end else begin
         split_in.days = q2_ff;
         r_fix         = r2_ff;
      end
      split_in.sod = {r_fix[DAY_R_W-1:0], lo2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         local_sec_ff <= local_sec_in;
         q1_ff        <= q1_in;
         x1_ff        <= x1_in;
         lo1_ff       <= lo1_in;
         q2_ff        <= q2_in;
         r2_ff        <= r2_in;
         lo2_ff       <= lo2_in;
         split_ff     <= split_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_split = split_ff;

endmodule

FILE: hdl/stc_date_split.sv
`timescale 1ns / 1ps

module stc_date_split (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [stc_pkg::DAYS_W-1:0]   days,
   output logic                         out_valid,
   output logic [stc_pkg::YEAR_W-1:0]   year,
   output logic [stc_pkg::MONTH_W-1:0]  month,
   output logic [stc_pkg::MDAY_W-1:0]   day_of_month
);
   import stc_pkg::*;

   localparam int unsigned STAGES = 4;

   logic [STAGES-1:0]     valid_ff, valid_in;

   logic [DAYS_W-1:0]     days_adj;
   logic [YR_PROD_W-1:0]  yr_prod;
   logic [YR_V_W-1:0]     v4_ff, v4_in;
   logic [YR_IDX_W-1:0]   q4_ff, q4_in;
   logic [DAYS_W-1:0]     d4_ff;

   logic [YR_MUL_W-1:0]   yr_mul;
   logic [YR_REM_W-1:0]   yr_rem;
   logic [YR_IDX_W-1:0]   n5_ff, n5_in;
   logic [DAYS_W-1:0]     d5_ff;

   logic [DAYS_W-1:0]     start6;
   logic [DOY_W-1:0]      doy6_ff, doy6_in;
   logic                  leap6_ff, leap6_in;
   logic [YR_IDX_W-1:0]   n6_ff;

   logic [MONTH_W-1:0]    mon_idx;
   logic [DOY_W-1:0]      mday0;
   logic [YEAR_W-1:0]     year_ff, year_in;
   logic [MONTH_W-1:0]    month_ff, month_in;
   logic [MDAY_W-1:0]     mday_ff, mday_in;

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   // stage 4: year estimate from 1461-day cycles
   assign days_adj = (days >= DAYS_W'(YEAR_2101_START)) ? days + DAYS_W'(1) : days;
   assign v4_in    = {days_adj, 2'b00} + YR_V_W'(YR_BIAS);
   assign yr_prod  = YR_PROD_W'(v4_in) * YR_PROD_W'(YR_RECIP);
   assign q4_in    = yr_prod[YR_PROD_W-1 -: YR_IDX_W];

   // stage 5: correct the estimate
   assign yr_mul = YR_MUL_W'(q4_ff) * YR_MUL_W'(YR_CYCLE);
   assign yr_rem = YR_REM_W'(YR_MUL_W'(v4_ff) - yr_mul);
   assign n5_in  = (yr_rem >= YR_REM_W'(YR_CYCLE)) ? q4_ff : q4_ff - YR_IDX_W'(1);

   // stage 6: day of year and leap flag
   assign start6   = year_start(n5_ff);
   assign doy6_in  = DOY_W'(d5_ff - start6);
   assign leap6_in = (n5_ff[1:0] == 2'd2) && (n5_ff != YR_IDX_W'(YR_2100_IDX));

   // stage 7: month and day
   always_comb begin
      mon_idx = '0;
      for (int m = 1; m < 12; m++) begin
         if (doy6_ff >= month_start(MONTH_W'(m), leap6_ff)) begin
            mon_idx = MONTH_W'(m);
         end
      end
      mday0    = doy6_ff - month_start(mon_idx, leap6_ff);
      month_in = mon_idx + MONTH_W'(1);
      mday_in  = MDAY_W'(mday0) + MDAY_W'(1);
      year_in  = YEAR_W'(n6_ff) + YEAR_W'(BASE_YEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v4_ff    <= v4_in;
         q4_ff    <= q4_in;
         d4_ff    <= days;
         n5_ff    <= n5_in;
         d5_ff    <= d4_ff;
         doy6_ff  <= doy6_in;
         leap6_ff <= leap6_in;
         n6_ff    <= n5_ff;
         year_ff  <= year_in;
         month_ff <= month_in;
         mday_ff  <= mday_in;
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign year         = year_ff;
   assign month        = month_ff;
   assign day_of_month = mday_ff;

endmodule

FILE: hdl/stc_time_split.sv
`timescale 1ns / 1ps

module stc_time_split (
   input  logic                          clock,
   input  logic                          en,
   input  logic [stc_pkg::SOD_W-1:0]     sod,
   output logic [stc_pkg::HOUR_W-1:0]    hour,
   output logic [stc_pkg::MINUTE_W-1:0]  minute,
   output logic [stc_pkg::SECOND_W-1:0]  second
);
   import stc_pkg::*;

   logic [MIN_PROD_W-1:0] min_prod;
   logic [MT_W-1:0]       mt4_ff, mt4_in;
   logic [SOD_W-1:0]      sod4_ff;

   logic [SOD_W-1:0]      sec_mul;
   logic [MT_REM_W-1:0]   sec_rem;
   logic [MT_W-1:0]       mt5_ff, mt5_in;
   logic [SECOND_W-1:0]   sec5_ff, sec5_in;

   logic [HR_PROD_W-1:0]  hr_prod;
   logic [HOUR_W-1:0]     h6_ff, h6_in;
   logic [MT_W-1:0]       mt6_ff;
   logic [SECOND_W-1:0]   sec6_ff;

   logic [MT_W-1:0]       min_mul;
   logic [MT_REM_W-1:0]   min_rem;
   logic [HOUR_W-1:0]     hour_ff, hour_in;
   logic [MINUTE_W-1:0]   minute_ff, minute_in;
   logic [SECOND_W-1:0]   second_ff;

   // stage 4: minute-of-day estimate
   assign min_prod = MIN_PROD_W'(sod[SOD_W-1:2]) * MIN_PROD_W'(MIN_RECIP);
   assign mt4_in   = min_prod[MIN_SHIFT +: MT_W];

   // stage 5: correct, split off seconds
   assign sec_mul = SOD_W'(mt4_ff) * SOD_W'(SIXTY);
   assign sec_rem = MT_REM_W'(sod4_ff - sec_mul);
   always_comb begin
      if (sec_rem >= MT_REM_W'(SIXTY)) begin
         mt5_in  = mt4_ff + MT_W'(1);
         sec5_in = SECOND_W'(sec_rem - MT_REM_W'(SIXTY));
      end else begin
         mt5_in  = mt4_ff;
         sec5_in = SECOND_W'(sec_rem);
      end
   end

   // stage 6: hour estimate
   assign hr_prod = HR_PROD_W'(mt5_ff[MT_W-1:2]) * HR_PROD_W'(MIN_RECIP);
   assign h6_in   = hr_prod[MIN_SHIFT +: HOUR_W];

   // stage 7: correct, split off minutes
   assign min_mul = MT_W'(h6_ff) * MT_W'(SIXTY);
   assign min_rem = MT_REM_W'(mt6_ff - min_mul);
   always_comb begin
      if (min_rem >= MT_REM_W'(SIXTY)) begin
         hour_in   = h6_ff + HOUR_W'(1);
         minute_in = MINUTE_W'(min_rem - MT_REM_W'(SIXTY));
      end else begin
         hour_in   = h6_ff;
         minute_in = MINUTE_W'(min_rem);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mt4_ff    <= mt4_in;
         sod4_ff   <= sod;
         mt5_ff    <= mt5_in;
         sec5_ff   <= sec5_in;
         h6_ff     <= h6_in;
         mt6_ff    <= mt5_ff;
         sec6_ff   <= sec5_ff;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= sec6_ff;
      end
   end

   assign hour   = hour_ff;
   assign minute = minute_ff;
   assign second = second_ff;

endmodule

FILE: hdl/seconds_to_calendar_date.sv
`timescale 1ns / 1ps

// Converts unsigned seconds since 1970-01-01 00:00:00 UTC, plus the whole-hour
// zone offset in the csr register (reset value 8), into local year, month, day,
// hour, minute and second under the Gregorian rule, 2100 included. The pipeline
// is eight register stages deep, and one beat is taken every cycle while the output
// is not stalled. The last stage is the output register; while it holds a beat
// that is not taken, the whole pipeline stops and req ready goes low. Write the
// zone offset only while the pipeline is empty.

module seconds_to_calendar_date (
   input  logic                        clock,
   input  logic                        reset,
   stc_req_if.sink                     req_if,
   stc_rsp_if.source                   rsp_if,
   input  logic                        csr_we,
   input  logic [stc_pkg::ZONE_W-1:0]  csr_wdata
);
   import stc_pkg::*;

   logic [ZONE_W-1:0] zone_ff, zone_in;
   logic              advance;
   logic              split_valid;
   day_split_type     split;

   assign zone_in = csr_we ? csr_wdata : zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else begin
         zone_ff <= zone_in;
      end
   end

   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;

   stc_day_split u_day_split (
      .clock             (clock),
      .reset             (reset),
      .en                (advance),
      .in_valid          (req_if.valid),
      .epoch_seconds     (req_if.epoch_seconds),
      .zone_offset_hours (zone_ff),
      .out_valid         (split_valid),
      .out_split         (split)
   );

   stc_date_split u_date_split (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (split_valid),
      .days         (split.days),
      .out_valid    (rsp_if.valid),
      .year         (rsp_if.year),
      .month        (rsp_if.month),
      .day_of_month (rsp_if.day_of_month)
   );

   stc_time_split u_time_split (
      .clock  (clock),
      .en     (advance),
      .sod    (split.sod),
      .hour   (rsp_if.hour),
      .minute (rsp_if.minute),
      .second (rsp_if.second)
   );

endmodule

FILE: hdl/stc_checker.sv
`timescale 1ns / 1ps

module stc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [stc_pkg::YEAR_W-1:0]    year,
   input  logic [stc_pkg::MONTH_W-1:0]   month,
   input  logic [stc_pkg::MDAY_W-1:0]    day_of_month,
   input  logic [stc_pkg::HOUR_W-1:0]    hour,
   input  logic [stc_pkg::MINUTE_W-1:0]  minute,
   input  logic [stc_pkg::SECOND_W-1:0]  second
);
   import stc_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(year) && $stable(month)
         && $stable(day_of_month) && $stable(hour) && $stable(minute) && $stable(second))
      else $error("rsp beat changed while stalled");

   // empty output stage never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty output stage");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> year >= YEAR_W'(1970) && year <= YEAR_W'(2106)
         && month >= MONTH_W'(1) && month <= MONTH_W'(12)
         && day_of_month >= MDAY_W'(1) && day_of_month <= MDAY_W'(31))
      else $error("date out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> hour <= HOUR_W'(23) && minute <= MINUTE_W'(59)
         && second <= SECOND_W'(59))
      else $error("time out of range");

endmodule

bind seconds_to_calendar_date stc_checker u_stc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .year         (rsp_if.year),
   .month        (rsp_if.month),
   .day_of_month (rsp_if.day_of_month),
   .hour         (rsp_if.hour),
   .minute       (rsp_if.minute),
   .second       (rsp_if.second)
);
